@@ rtl/jsu_pkg.sv @@
// Package for the JSON string unescaper: decoder modes, result codes and
// the structs passed between the decoder, the result buffer and the top level.
// No dependencies.
package jsu_pkg;

   localparam int LINE_BITS_DEFAULT = 24;
   localparam int OUT_LINE_BITS     = 24;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_STR  = 2'd1,
      MODE_ESC  = 2'd2,
      MODE_HEX  = 2'd3
   } mode_type;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_EXPECTED   = 3'd1;
   localparam logic [2:0] ERR_UNTERM     = 3'd2;
   localparam logic [2:0] ERR_BAD_HEX    = 3'd3;
   localparam logic [2:0] ERR_SURROGATE  = 3'd4;
   localparam logic [2:0] ERR_UNKNOWN_ESC = 3'd5;

   typedef struct packed {
      mode_type    mode;
      logic [1:0]  hex_cnt;
      logic [15:0] code_point;
   } jsu_state_type;

   typedef struct packed {
      logic [1:0]       count;
      logic [2:0][7:0]  bytes;
      logic [1:0]       kind;
      logic [2:0]       error_code;
   } jsu_result_type;

endpackage

@@ rtl/jsu_req_if.sv @@
// Input channel of the JSON string unescaper: one text byte per transfer.
// No dependencies.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

@@ rtl/jsu_rsp_if.sv @@
// Result channel of the JSON string unescaper: one result item per transfer.
// Depends on jsu_pkg for the line number width.
interface jsu_rsp_if
   import jsu_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic [7:0]               out_byte;
   logic [1:0]               kind;
   logic [2:0]               error_code;
   logic [OUT_LINE_BITS-1:0] line_number;
   logic                     last_of_run;

   modport source (output valid, output out_byte, output kind, output error_code,
                   output line_number, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input kind, input error_code,
                   input line_number, input last_of_run, output ready);
endinterface

@@ rtl/jsu_decode.sv @@
// Combinational decoder: from the current state, line count and one text byte
// it forms the next state and up to three result items. Depends on jsu_pkg.
module jsu_decode
   import jsu_pkg::*;
#(
   parameter int LINE_BITS = LINE_BITS_DEFAULT
) (
   input  jsu_state_type        state,
   input  logic [LINE_BITS-1:0] line_count,
   input  logic [7:0]           text_byte,
   output jsu_state_type        state_next,
   output logic [LINE_BITS-1:0] line_next,
   output jsu_result_type       result
);

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_BSL   = 8'h5C;
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_F     = 8'h66;
   localparam logic [7:0] CHAR_N     = 8'h6E;
   localparam logic [7:0] CHAR_R     = 8'h72;
   localparam logic [7:0] CHAR_T     = 8'h74;
   localparam logic [7:0] CHAR_U     = 8'h75;

   logic        bump;
   logic        is_hex;
   logic [3:0]  nibble;
   logic [15:0] cp_new;

   always_comb begin
      is_hex = 1'b1;
      nibble = 4'd0;
      case (text_byte) inside
         [8'h30:8'h39]: nibble = text_byte[3:0];
         [8'h41:8'h46], [8'h61:8'h66]: nibble = text_byte[3:0] + 4'd9;
         default: is_hex = 1'b0;
      endcase
   end

   assign cp_new = {state.code_point[11:0], nibble};
   assign line_next = (bump && !(&line_count)) ? line_count + 1'b1 : line_count;

   always_comb begin
      state_next = state;
      bump = 1'b0;
      result.count = 2'd0;
      result.bytes = '0;
      result.kind = KIND_DATA;
      result.error_code = ERR_NONE;
      case (state.mode)
         MODE_IDLE: begin
            if (text_byte == CHAR_LF) begin
               bump = 1'b1;
            end else if (text_byte == CHAR_QUOTE) begin
               state_next.mode = MODE_STR;
            end else if (!(text_byte inside {CHAR_SPACE, CHAR_TAB, CHAR_CR})) begin
               result.count = 2'd1;
               result.kind = KIND_ERR;
               result.error_code = ERR_EXPECTED;
            end
         end
         MODE_STR: begin
            if (text_byte == CHAR_NUL) begin
               result.count = 2'd1;
               result.kind = KIND_ERR;
               result.error_code = ERR_UNTERM;
               state_next = '{mode: MODE_IDLE, hex_cnt: 2'd0, code_point: 16'd0};
            end else if (text_byte == CHAR_QUOTE) begin
               state_next.mode = MODE_IDLE;
               result.count = 2'd1;
               result.kind = KIND_END;
            end else if (text_byte == CHAR_BSL) begin
               state_next.mode = MODE_ESC;
            end else begin
               bump = (text_byte == CHAR_LF);
               result.count = 2'd1;
               result.bytes[0] = text_byte;
            end
         end
         MODE_ESC: begin
            state_next.mode = MODE_STR;
            result.count = 2'd1;
            case (text_byte)
               CHAR_QUOTE, CHAR_BSL, CHAR_SLASH: result.bytes[0] = text_byte;
               CHAR_B: result.bytes[0] = 8'h08;
               CHAR_F: result.bytes[0] = 8'h0C;
               CHAR_N: result.bytes[0] = CHAR_LF;
               CHAR_R: result.bytes[0] = CHAR_CR;
               CHAR_T: result.bytes[0] = CHAR_TAB;
               CHAR_U: begin
                  result.count = 2'd0;
                  state_next = '{mode: MODE_HEX, hex_cnt: 2'd0, code_point: 16'd0};
               end
               default: begin
                  result.kind = KIND_ERR;
                  result.error_code = ERR_UNKNOWN_ESC;
                  state_next = '{mode: MODE_IDLE, hex_cnt: 2'd0, code_point: 16'd0};
               end
            endcase
         end
         default: begin
            if (!is_hex) begin
               result.count = 2'd1;
               result.kind = KIND_ERR;
               result.error_code = ERR_BAD_HEX;
               state_next = '{mode: MODE_IDLE, hex_cnt: 2'd0, code_point: 16'd0};
            end else if (state.hex_cnt != 2'd3) begin
               state_next.hex_cnt = state.hex_cnt + 2'd1;
               state_next.code_point = cp_new;
            end else if (cp_new[15:11] == 5'b11011) begin
               result.count = 2'd1;
               result.kind = KIND_ERR;
               result.error_code = ERR_SURROGATE;
               state_next = '{mode: MODE_IDLE, hex_cnt: 2'd0, code_point: 16'd0};
            end else begin
               state_next = '{mode: MODE_STR, hex_cnt: 2'd0, code_point: cp_new};
               if (cp_new[15:7] == 9'd0) begin
                  result.count = 2'd1;
                  result.bytes[0] = cp_new[7:0];
               end else if (cp_new[15:11] == 5'd0) begin
                  result.count = 2'd2;
                  result.bytes[0] = {3'b110, cp_new[10:6]};
                  result.bytes[1] = {2'b10, cp_new[5:0]};
               end else begin
                  result.count = 2'd3;
                  result.bytes[0] = {4'b1110, cp_new[15:12]};
                  result.bytes[1] = {2'b10, cp_new[11:6]};
                  result.bytes[2] = {2'b10, cp_new[5:0]};
               end
            end
         end
      endcase
   end

endmodule

@@ rtl/jsu_result_buffer.sv @@
// Result register that holds the up to three result items of one text byte
// and hands them out one per transfer. Depends on jsu_pkg.
module jsu_result_buffer
   import jsu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  jsu_result_type           load_result,
   input  logic [OUT_LINE_BITS-1:0] load_line,
   output logic                     free,
   output logic                     valid,
   input  logic                     ready,
   output logic [7:0]               out_byte,
   output logic [1:0]               kind,
   output logic [2:0]               error_code,
   output logic [OUT_LINE_BITS-1:0] line_number,
   output logic                     last_of_run
);

   logic [1:0]               rem_ff, rem_in;
   logic [2:0][7:0]          bytes_ff, bytes_in;
   logic [1:0]               kind_ff;
   logic [2:0]               err_ff;
   logic [OUT_LINE_BITS-1:0] line_ff;
   logic                     xfer;

   assign valid       = (rem_ff != 2'd0);
   assign xfer        = valid && ready;
   assign free        = (rem_ff == 2'd0) || (rem_ff == 2'd1 && ready);
   assign out_byte    = bytes_ff[0];
   assign kind        = kind_ff;
   assign error_code  = err_ff;
   assign line_number = line_ff;
   assign last_of_run = (rem_ff == 2'd1);

   always_comb begin
      rem_in   = rem_ff;
      bytes_in = bytes_ff;
      if (xfer) begin
         rem_in   = rem_ff - 2'd1;
         bytes_in = {8'h00, bytes_ff[2:1]};
      end
      if (load) begin
         rem_in   = load_result.count;
         bytes_in = load_result.bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
      end
      bytes_ff <= bytes_in;
      if (load) begin
         kind_ff <= load_result.kind;
         err_ff  <= load_result.error_code;
         line_ff <= load_line;
      end
   end

endmodule

@@ rtl/json_string_unescaper.sv @@
// JSON string unescaper top level: input register, decoder and result buffer.
// A byte waits in the input register, is decoded, and its results load into the buffer.
// Throughput: one text byte per cycle while results are taken; a \uXXXX escape that
// forms two or three UTF-8 bytes holds a later byte with results while the buffer drains.
// Reset (synchronous) empties both registers, sets the mode to idle and the line
// count to one. Depends on jsu_pkg, jsu_req_if, jsu_rsp_if, jsu_decode, jsu_result_buffer.
module json_string_unescaper
   import jsu_pkg::*;
#(
   parameter int LINE_BITS = LINE_BITS_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   jsu_req_if.sink   req_ch,
   jsu_rsp_if.source rsp_ch
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   jsu_state_type        state_ff, state_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   jsu_result_type       result;
   logic                 buf_free;
   logic                 consume;
   logic [LINE_BITS+OUT_LINE_BITS-1:0] line_wide;

   jsu_decode #(.LINE_BITS(LINE_BITS)) u_decode (
      .state      (state_ff),
      .line_count (line_ff),
      .text_byte  (in_byte_ff),
      .state_next (state_in),
      .line_next  (line_in),
      .result     (result)
   );

   assign consume      = in_valid_ff && (result.count == 2'd0 || buf_free);
   assign req_ch.ready = !in_valid_ff || consume;
   assign in_valid_in  = req_ch.valid || (in_valid_ff && !consume);
   assign line_wide    = {{OUT_LINE_BITS{1'b0}}, line_in};

   jsu_result_buffer u_buffer (
      .clock       (clock),
      .reset       (reset),
      .load        (consume && result.count != 2'd0),
      .load_result (result),
      .load_line   (line_wide[OUT_LINE_BITS-1:0]),
      .free        (buf_free),
      .valid       (rsp_ch.valid),
      .ready       (rsp_ch.ready),
      .out_byte    (rsp_ch.out_byte),
      .kind        (rsp_ch.kind),
      .error_code  (rsp_ch.error_code),
      .line_number (rsp_ch.line_number),
      .last_of_run (rsp_ch.last_of_run)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '{mode: MODE_IDLE, hex_cnt: 2'd0, code_point: 16'd0};
         line_ff     <= {{(LINE_BITS-1){1'b0}}, 1'b1};
      end else begin
         in_valid_ff <= in_valid_in;
         if (consume) begin
            state_ff <= state_in;
            line_ff  <= line_in;
         end
      end
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.text_byte;
      end
   end

endmodule

@@ rtl/jsu_checker.sv @@
// Port-level checker for the JSON string unescaper and its bind to the top level.
// Depends on jsu_pkg and json_string_unescaper.
module jsu_checker
   import jsu_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [7:0]               out_byte,
   input logic [1:0]               kind,
   input logic [2:0]               error_code,
   input logic [OUT_LINE_BITS-1:0] line_number,
   input logic                     last_of_run
);

   // A stalled result keeps its whole payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(kind)
         && $stable(error_code) && $stable(line_number) && $stable(last_of_run))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // End markers and errors are always the only result of their byte.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind != KIND_DATA |-> last_of_run)
      else $error("end or error result not last of run");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((kind == KIND_ERR) == (error_code != ERR_NONE)))
      else $error("error code does not match result kind");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind != KIND_DATA |-> out_byte == 8'h00)
      else $error("nonzero byte on end or error result");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .out_byte    (rsp_ch.out_byte),
   .kind        (rsp_ch.kind),
   .error_code  (rsp_ch.error_code),
   .line_number (rsp_ch.line_number),
   .last_of_run (rsp_ch.last_of_run)
);
